### design/tfs_pkg.sv
// Shared types, register indexes and helpers for the throttle filter and scale block.
package tfs_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int DATA_W = 16;
	localparam int PROD_W = 2 * DATA_W;
	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_RISE_BW = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FALL_BW = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_OFFSET = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_SLOPE = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_DIVISOR = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TRQ_OFFSET = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_TRQ_SLOPE = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_TRQ_DIVISOR = 4'd7;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [DATA_W-1:0] c;
	} mul_req_t;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_rsp_t;

	function automatic logic [DATA_W-1:0] nonzero(input logic [DATA_W-1:0] v);
		return (v == '0) ? DATA_W'(1) : v;
	endfunction

	function automatic logic [DATA_W-1:0] floor_sub(input logic [DATA_W-1:0] x,
		input logic [DATA_W-1:0] y);
		return (x > y) ? (x - y) : '0;
	endfunction

endpackage

### design/tfs_mul.sv
// Bit-serial shift-add multiplier with addend, one multiplier bit per cycle.
module tfs_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tfs_pkg::mul_req_t                   req,
	output tfs_pkg::unit_rsp_t                  rsp,
	output logic [tfs_pkg::PROD_W-1:0]          prod
);
	import tfs_pkg::*;

	localparam int CNT_W = $clog2(DATA_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(DATA_W - 1);

	logic [DATA_W-1:0] a_q;
	logic [DATA_W-1:0] hi_q;
	logic [DATA_W-1:0] lo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic [DATA_W:0]   sum;

	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			hi_q <= req.c;
			lo_q <= req.b;
		end else if (busy_q) begin
			hi_q <= sum[DATA_W:1];
			lo_q <= {sum[0], lo_q[DATA_W-1:1]};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = busy_q && (cnt_q == LAST);
	assign prod = {hi_q, lo_q};

endmodule

### design/tfs_div.sv
// Restoring bit-serial divider, one quotient bit per cycle; quo is complete in the done cycle.
module tfs_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tfs_pkg::div_req_t                   req,
	input  logic [tfs_pkg::PROD_W-1:0]          dividend,
	output tfs_pkg::unit_rsp_t                  rsp,
	output logic [tfs_pkg::PROD_W-1:0]          quo
);
	import tfs_pkg::*;

	localparam int CNT_W = $clog2(PROD_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(PROD_W - 1);

	logic [DATA_W-1:0] d_q;
	logic [DATA_W-1:0] rem_q;
	logic [PROD_W-1:0] dq_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic [DATA_W:0]   shifted;
	logic              ge;
	logic [DATA_W:0]   diff;

	assign shifted = {rem_q, dq_q[PROD_W-1]};
	assign ge = shifted >= {1'b0, d_q};
	assign diff = shifted - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			d_q <= req.divisor;
			rem_q <= '0;
			dq_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
			dq_q <= {dq_q[PROD_W-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = busy_q && (cnt_q == LAST);
	assign quo = {dq_q[PROD_W-2:0], ge};

endmodule

### design/throttle_filter_and_scale_top.sv
// Top level: configuration registers, sequencer and output register of the throttle filter.
// Sequence: filter pair, throttle pair, torque pair, then output register load.
// An all-ones (invalid) sample skips the filter pair; a new sample is taken only when idle.
// The shared bit-serial multiplier and divider run three multiply/divide pairs per valid sample.
// A new sample beat is taken while the previous result waits in the output register.
// Reset (arst_n low) clears the average to 0 and loads the register defaults.
module throttle_filter_and_scale_top #(
	parameter int SAMPLE_BITS = tfs_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [tfs_pkg::DATA_W-1:0]           adc_sample,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [tfs_pkg::DATA_W-1:0]           filtered_adc,
	output logic [tfs_pkg::DATA_W-1:0]           throttle_level,
	output logic signed [tfs_pkg::DATA_W-1:0]    torque_request,
	input  logic                                 wr_en,
	input  logic [tfs_pkg::CFG_IDX_W-1:0]        wr_index,
	input  logic [tfs_pkg::DATA_W-1:0]           wr_data
);
	import tfs_pkg::*;

	localparam logic [DATA_W-1:0] SMASK = DATA_W'((32'd1 << SAMPLE_BITS) - 32'd1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_FMUL = 3'd1;
	localparam logic [2:0] ST_FDIV = 3'd2;
	localparam logic [2:0] ST_TMUL = 3'd3;
	localparam logic [2:0] ST_TDIV = 3'd4;
	localparam logic [2:0] ST_QMUL = 3'd5;
	localparam logic [2:0] ST_QDIV = 3'd6;
	localparam logic [2:0] ST_OUT = 3'd7;

	logic [DATA_W-1:0]        rise_bw_q;
	logic [DATA_W-1:0]        fall_bw_q;
	logic [DATA_W-1:0]        thr_off_q;
	logic [DATA_W-2:0]        thr_slope_q;
	logic [DATA_W-2:0]        thr_div_q;
	logic [DATA_W-1:0]        trq_off_q;
	logic signed [DATA_W-1:0] trq_slope_q;
	logic [DATA_W-2:0]        trq_div_q;

	logic [2:0]         state_q;
	logic               start_q;
	logic [DATA_W-1:0]  avg_q;
	logic [DATA_W-1:0]  samp_q;
	logic [DATA_W-1:0]  thr_q;
	logic [DATA_W-1:0]  trq_q;
	logic               out_valid_q;
	logic [DATA_W-1:0]  out_avg_q;
	logic [DATA_W-1:0]  out_thr_q;
	logic [DATA_W-1:0]  out_trq_q;

	mul_req_t           mul_req;
	div_req_t           div_req;
	unit_rsp_t          mul_rsp;
	unit_rsp_t          div_rsp;
	logic [PROD_W-1:0]  prod;
	logic [PROD_W-1:0]  quo;

	logic [DATA_W-1:0]  samp_in;
	logic [DATA_W-1:0]  bw;
	logic [DATA_W-1:0]  slope_mag;
	logic [DATA_W-1:0]  thr_sat;
	logic [DATA_W-1:0]  trq_sat;
	logic               accept;
	logic               out_load;

	assign samp_in = adc_sample & SMASK;
	assign bw = nonzero((samp_q > avg_q) ? rise_bw_q : fall_bw_q);
	assign slope_mag = trq_slope_q[DATA_W-1] ? DATA_W'(-trq_slope_q) : DATA_W'(trq_slope_q);
	assign thr_sat = (quo > PROD_W'(16'hFFFF)) ? 16'hFFFF : quo[DATA_W-1:0];

	always_comb begin
		if (trq_slope_q[DATA_W-1]) begin
			trq_sat = (quo > PROD_W'(16'h8000)) ? 16'h8000 : DATA_W'(-quo[DATA_W-1:0]);
		end else begin
			trq_sat = (quo > PROD_W'(16'h7FFF)) ? 16'h7FFF : quo[DATA_W-1:0];
		end
	end

	always_comb begin
		mul_req.start = start_q && (state_q == ST_FMUL || state_q == ST_TMUL ||
			state_q == ST_QMUL);
		div_req.start = start_q && (state_q == ST_FDIV || state_q == ST_TDIV ||
			state_q == ST_QDIV);
		mul_req.a = '0;
		mul_req.b = '0;
		mul_req.c = '0;
		div_req.divisor = DATA_W'(1);
		unique case (state_q)
			ST_FMUL: begin
				mul_req.a = bw - DATA_W'(1);
				mul_req.b = avg_q;
				mul_req.c = samp_q;
			end
			ST_FDIV: div_req.divisor = bw;
			ST_TMUL: begin
				mul_req.a = {1'b0, thr_slope_q};
				mul_req.b = floor_sub(avg_q, thr_off_q);
			end
			ST_TDIV: div_req.divisor = nonzero({1'b0, thr_div_q});
			ST_QMUL: begin
				mul_req.a = slope_mag;
				mul_req.b = floor_sub(thr_q, trq_off_q);
			end
			ST_QDIV: div_req.divisor = nonzero({1'b0, trq_div_q});
			default: begin
			end
		endcase
	end

	tfs_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp),
		.prod   (prod)
	);

	tfs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (prod),
		.rsp      (div_rsp),
		.quo      (quo)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_bw_q <= 16'd16;
			fall_bw_q <= 16'd16;
			thr_off_q <= '0;
			thr_slope_q <= 15'd1;
			thr_div_q <= 15'd1;
			trq_off_q <= '0;
			trq_slope_q <= 16'sd1;
			trq_div_q <= 15'd1;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_RISE_BW: rise_bw_q <= wr_data;
				CFG_FALL_BW: fall_bw_q <= wr_data;
				CFG_THR_OFFSET: thr_off_q <= wr_data;
				CFG_THR_SLOPE: thr_slope_q <= wr_data[DATA_W-2:0];
				CFG_THR_DIVISOR: thr_div_q <= wr_data[DATA_W-2:0];
				CFG_TRQ_OFFSET: trq_off_q <= wr_data;
				CFG_TRQ_SLOPE: trq_slope_q <= wr_data;
				CFG_TRQ_DIVISOR: trq_div_q <= wr_data[DATA_W-2:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
			avg_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !out_ready);
			unique case (state_q) inside
				ST_IDLE: begin
					if (accept) begin
						start_q <= 1'b1;
						state_q <= (samp_in == SMASK) ? ST_TMUL : ST_FMUL;
					end
				end
				ST_FMUL, ST_TMUL, ST_QMUL: begin
					start_q <= mul_rsp.done;
					if (mul_rsp.done) begin
						state_q <= state_q + 3'd1;
					end
				end
				ST_FDIV, ST_TDIV, ST_QDIV: begin
					start_q <= div_rsp.done && (state_q != ST_QDIV);
					if (div_rsp.done) begin
						state_q <= state_q + 3'd1;
						if (state_q == ST_FDIV) begin
							avg_q <= quo[DATA_W-1:0];
						end
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			samp_q <= samp_in;
		end
		if (state_q == ST_TDIV && div_rsp.done) begin
			thr_q <= thr_sat;
		end
		if (state_q == ST_QDIV && div_rsp.done) begin
			trq_q <= trq_sat;
		end
		if (out_load) begin
			out_avg_q <= avg_q;
			out_thr_q <= thr_q;
			out_trq_q <= trq_q;
		end
	end

	assign out_valid = out_valid_q;
	assign filtered_adc = out_avg_q;
	assign throttle_level = out_thr_q;
	assign torque_request = out_trq_q;

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_rsp.busy && div_rsp.busy))
		else $error("multiplier and divider busy together");

	a_valid_sample_filters: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (samp_in != SMASK) |=> state_q == ST_FMUL && start_q)
		else $error("valid sample did not start the filter update");

	a_avg_held: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_FDIV |=> $stable(avg_q))
		else $error("average changed outside the filter divide");

	a_result_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid && filtered_adc == $past(avg_q) && state_q == ST_IDLE)
		else $error("result beat not loaded from the current average");

endmodule

### bench/throttle_filter_and_scale_top_test.sv
// Self-checking testbench for the throttle filter and scale block: directed table, then random phases.
module throttle_filter_and_scale_top_test;
	import tfs_pkg::*;

	localparam logic [DATA_W-1:0] SAMPLE_INVALID = 16'hFFFF;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = CFG_TRQ_DIVISOR + 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LAST = 4'd15;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct packed {
		logic [DATA_W-1:0] avg;
		logic [DATA_W-1:0] thr;
		logic [DATA_W-1:0] trq;
	} scaled_result_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [DATA_W-1:0]    data;
		logic                 typed;
		scaled_result_t       want;
	} plan_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [DATA_W-1:0]    adc_sample = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [DATA_W-1:0]    filtered_adc;
	logic [DATA_W-1:0]    throttle_level;
	logic signed [DATA_W-1:0] torque_request;
	logic                 wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [DATA_W-1:0]    wr_data = '0;

	logic steady = 1'b0;
	int mismatches = 0;
	scaled_result_t pending_results [$];
	plan_row_t plan [$];

	// predictor state
	logic [15:0] avg_model = '0;
	logic [15:0] rise_bw = 16'd16;
	logic [15:0] fall_bw = 16'd16;
	logic [15:0] thr_offset = '0;
	logic [14:0] thr_slope = 15'd1;
	logic [14:0] thr_div = 15'd1;
	logic [15:0] trq_offset = '0;
	logic signed [15:0] trq_slope = 16'sd1;
	logic [14:0] trq_div = 15'd1;

	throttle_filter_and_scale_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.adc_sample     (adc_sample),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.filtered_adc   (filtered_adc),
		.throttle_level (throttle_level),
		.torque_request (torque_request),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data)
	);

	always #1 clk = ~clk;

	function automatic scaled_result_t filter_and_scale(input logic [15:0] s);
		logic [15:0] bw;
		logic [15:0] diff;
		longint unsigned acc;
		longint unsigned thr;
		longint unsigned udiv;
		longint sdiff;
		longint sslope;
		longint sdiv;
		longint trq;
		scaled_result_t r;
		if (s != SAMPLE_INVALID) begin
			bw = (s > avg_model) ? rise_bw : fall_bw;
			if (bw == '0) bw = 16'd1;
			acc = bw - 16'd1;
			acc = acc * avg_model + s;
			udiv = bw;
			avg_model = 16'(acc / udiv);
		end
		diff = (avg_model > thr_offset) ? avg_model - thr_offset : '0;
		udiv = (thr_div == '0) ? 1 : thr_div;
		thr = thr_slope;
		thr = thr * diff / udiv;
		if (thr > 65535) thr = 65535;
		diff = (16'(thr) > trq_offset) ? 16'(thr) - trq_offset : '0;
		sdiff = diff;
		sslope = trq_slope;
		sdiv = (trq_div == '0) ? 1 : trq_div;
		trq = sslope * sdiff / sdiv;
		if (trq > 32767) trq = 32767;
		else if (trq < -32768) trq = -32768;
		r.avg = avg_model;
		r.thr = 16'(thr);
		r.trq = 16'(trq);
		return r;
	endfunction

	function automatic void set_register(input logic [3:0] idx, input logic [15:0] data);
		case (idx)
			CFG_RISE_BW:     rise_bw = data;
			CFG_FALL_BW:     fall_bw = data;
			CFG_THR_OFFSET:  thr_offset = data;
			CFG_THR_SLOPE:   thr_slope = data[14:0];
			CFG_THR_DIVISOR: thr_div = data[14:0];
			CFG_TRQ_OFFSET:  trq_offset = data;
			CFG_TRQ_SLOPE:   trq_slope = data;
			CFG_TRQ_DIVISOR: trq_div = data[14:0];
			default: ;
		endcase
	endfunction

	function automatic plan_row_t wr_row(input logic [3:0] idx, input logic [15:0] data);
		plan_row_t p;
		p = '0;
		p.kind = ROW_WRITE;
		p.idx = idx;
		p.data = data;
		return p;
	endfunction

	function automatic plan_row_t sample_row(input logic [15:0] s);
		plan_row_t p;
		p = '0;
		p.kind = ROW_SAMPLE;
		p.data = s;
		return p;
	endfunction

	function automatic plan_row_t typed_row(input logic [15:0] s, input logic [15:0] a,
		input logic [15:0] t, input logic [15:0] q);
		plan_row_t p;
		p = sample_row(s);
		p.typed = 1'b1;
		p.want = '{a, t, q};
		return p;
	endfunction

	function automatic logic [15:0] pick_reg_value();
		case ($urandom_range(0, 6))
			0: return 16'h0000;
			1: return 16'h0001;
			2: return 16'hFFFF;
			3: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
			4: return 16'($urandom_range(0, 64));
			5: return 16'($urandom_range(0, 1023));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 19))
			0: return SAMPLE_INVALID;
			1: return 16'h0000;
			2: return 16'hFFFE;
			3, 4, 5: return avg_model + 16'($urandom_range(0, 8)) - 16'd4;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
		input logic [15:0] want);
		$display("MISMATCH %s: got %h expected %h", what, got, want);
		mismatches++;
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_register(input logic [3:0] idx, input logic [15:0] data);
		hold_until_drained();
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(negedge clk);
		wr_en <= 1'b0;
		set_register(idx, data);
	endtask

	task automatic send_sample(input logic [15:0] s, input logic typed,
		input scaled_result_t want);
		scaled_result_t r;
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 11) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		adc_sample <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		r = filter_and_scale(s);
		pending_results.push_back(typed ? want : r);
	endtask

	task automatic program_random_settings();
		for (int k = CFG_RISE_BW; k <= CFG_TRQ_DIVISOR; k++)
			write_register(4'(k), pick_reg_value());
		if ($urandom_range(0, 2) == 0)
			write_register(4'($urandom_range(CFG_UNUSED_FIRST, CFG_UNUSED_LAST)),
				16'($urandom));
	endtask

	always @(negedge clk) begin
		out_ready <= steady || ($urandom_range(0, 99) >= 11);
	end

	always @(posedge clk) begin
		scaled_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected beat, filtered_adc", filtered_adc, '0);
			end else begin
				want = pending_results.pop_front();
				if (filtered_adc !== want.avg)
					report_mismatch("filtered_adc", filtered_adc, want.avg);
				if (throttle_level !== want.thr)
					report_mismatch("throttle_level", throttle_level, want.thr);
				if (torque_request !== want.trq)
					report_mismatch("torque_request", torque_request, want.trq);
			end
		end
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		plan = '{
			typed_row(16'h0000, 16'd0, 16'd0, 16'd0),
			typed_row(SAMPLE_INVALID, 16'd0, 16'd0, 16'd0),
			typed_row(16'hFFFE, 16'd4095, 16'd4095, 16'd4095),
			wr_row(CFG_RISE_BW, 16'h0000),
			typed_row(16'h8000, 16'd32768, 16'd32768, 16'h7FFF),
			wr_row(CFG_FALL_BW, 16'h0000),
			typed_row(16'h0001, 16'd1, 16'd1, 16'd1),
			wr_row(CFG_THR_SLOPE, 16'h7FFF),
			wr_row(CFG_THR_DIVISOR, 16'h0000),
			typed_row(16'hFFFE, 16'd65534, 16'hFFFF, 16'h7FFF),
			wr_row(CFG_TRQ_SLOPE, 16'h8000),
			typed_row(SAMPLE_INVALID, 16'd65534, 16'hFFFF, 16'h8000),
			wr_row(CFG_UNUSED_FIRST, 16'h1000),
			wr_row(CFG_UNUSED_FIRST + 4'd1, 16'h1000),
			wr_row(CFG_UNUSED_LAST, 16'h0003),
			typed_row(16'h0000, 16'd0, 16'd0, 16'd0),
			typed_row(16'hFFFE, 16'd65534, 16'hFFFF, 16'h8000),
			wr_row(CFG_THR_OFFSET, 16'hFFFF),
			typed_row(16'hFFFE, 16'd65534, 16'd0, 16'd0),
			wr_row(CFG_THR_OFFSET, 16'h0100),
			wr_row(CFG_THR_SLOPE, 16'h8003),
			wr_row(CFG_THR_DIVISOR, 16'hFFFF),
			sample_row(16'h1234),
			sample_row(16'hABCD),
			wr_row(CFG_TRQ_OFFSET, 16'hFFFF),
			wr_row(CFG_TRQ_DIVISOR, 16'h0000),
			sample_row(16'h7FFF),
			wr_row(CFG_TRQ_OFFSET, 16'h0000),
			wr_row(CFG_TRQ_SLOPE, 16'h7FFF),
			wr_row(CFG_TRQ_DIVISOR, 16'hFFFF),
			wr_row(CFG_THR_DIVISOR, 16'h0001),
			wr_row(CFG_THR_SLOPE, 16'h0001),
			wr_row(CFG_THR_OFFSET, 16'h0000),
			sample_row(16'h5555),
			sample_row(16'hAAAA),
			wr_row(CFG_RISE_BW, 16'hFFFF),
			wr_row(CFG_FALL_BW, 16'hFFFF),
			sample_row(16'h0000),
			sample_row(16'hFFFE),
			sample_row(SAMPLE_INVALID),
			wr_row(CFG_RISE_BW, 16'd16),
			wr_row(CFG_FALL_BW, 16'd3),
			sample_row(16'h4000),
			sample_row(16'h0010),
			sample_row(16'hC000)
		};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE)
				write_register(plan[i].idx, plan[i].data);
			else
				send_sample(plan[i].data, plan[i].typed, plan[i].want);
		end

		for (int phase = 0; phase < 8; phase++) begin
			steady = (phase == 3);
			program_random_settings();
			for (int n = 0; n < 150; n++) begin
				// in phase 5 only, hold off until drained once mid-phase
				if (n == 75 && phase == 5) hold_until_drained();
				send_sample(pick_sample(), 1'b0, '0);
			end
		end
		steady = 1'b0;

		hold_until_drained();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
